### hw/rtl/pgt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority goal table package
// Shared types and constants for the goal table front end, queue and engine.
// ----------------------------------------------------------------------------
package pgt_pkg;

   localparam int unsigned GOAL_SLOTS_DEF = 128;
   localparam int unsigned QUEUE_DEPTH    = 2;

   localparam logic [1:0] FUNC_PUSH     = 2'd0;
   localparam logic [1:0] FUNC_COMPLETE = 2'd1;
   localparam logic [1:0] FUNC_CANCEL   = 2'd2;
   localparam logic [1:0] FUNC_QUERY    = 2'd3;

   localparam logic [1:0] ST_PENDING   = 2'd0;
   localparam logic [1:0] ST_COMPLETED = 2'd1;
   localparam logic [1:0] ST_FAILED    = 2'd2;
   localparam logic [1:0] ST_CANCELLED = 2'd3;

   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_LIMIT  = 1'b1;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] goal_id;
      logic [15:0] priority_req;
      logic        success;
      logic [47:0] current_step;
   } req_type;

   typedef struct packed {
      logic [31:0] new_id;
      logic        found;
      logic        active_valid;
      logic [31:0] active_id;
      logic [15:0] active_priority;
      logic [7:0]  open_count;
   } rsp_type;

   // Classified command handed from the front end to the engine.
   typedef struct packed {
      logic        do_push;
      logic        do_mark;
      logic [1:0]  status;
      logic [31:0] goal_id;
      logic [15:0] priority_req;
      logic [47:0] current_step;
      logic [31:0] new_id;
   } cmd_type;

endpackage
`default_nettype wire

### hw/rtl/priority_goal_table_top.sv
`default_nettype none
// Each request is answered after two sequential passes over the slot memory,
// with the table updated between them.
// Further requests wait in the command queue while the engine works; busy rises while
// the command queue is full.
// Reset is synchronous: all slots empty, next id 1, enable 1, goal limit 128.
// The receiver cannot stall; each response is shown for one cycle.
module priority_goal_table_top #(
   parameter int unsigned GOAL_SLOTS = pgt_pkg::GOAL_SLOTS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  pgt_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output pgt_pkg::rsp_type  rsp_data,
   input  wire               csr_we,
   input  wire  [7:0]        csr_index,
   input  wire  [7:0]        csr_wdata
);

   logic             enable_ff;
   logic [7:0]       limit_ff;
   logic             take;
   logic             pop;
   logic             q_ne;
   logic             q_full;
   pgt_pkg::cmd_type fcmd;
   pgt_pkg::cmd_type qcmd;

   assign busy = q_full;
   assign take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         limit_ff  <= 8'd128;
      end else if (csr_we) begin
         if (csr_index == 8'(pgt_pkg::CSR_ENABLE)) begin
            enable_ff <= csr_wdata[0];
         end else if (csr_index == 8'(pgt_pkg::CSR_LIMIT)) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   pgt_front u_front (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .req    (req_data),
      .enable (enable_ff),
      .cmd    (fcmd)
   );

   pgt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (fcmd),
      .pop       (pop),
      .head      (qcmd),
      .not_empty (q_ne),
      .full      (q_full)
   );

   pgt_engine #(
      .GOAL_SLOTS (GOAL_SLOTS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_ne),
      .cmd        (qcmd),
      .cmd_pop    (pop),
      .goal_limit (limit_ff),
      .rsp_valid  (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule
`default_nettype wire

### hw/rtl/pgt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Goal table front end
// Accepts requests, classifies them and hands out goal ids.
// ----------------------------------------------------------------------------
module pgt_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               take,
   input  pgt_pkg::req_type  req,
   input  wire               enable,
   output pgt_pkg::cmd_type  cmd
);

   logic [31:0] next_id_ff, next_id_in;
   logic [31:0] id_plus1;
   logic [31:0] give_id;
   logic        push;

   assign push     = (req.func == pgt_pkg::FUNC_PUSH) && enable;
   assign id_plus1 = next_id_ff + 32'd1;
   // Id zero is never handed out; the counter steps over it.
   assign give_id  = (next_id_ff == 32'd0) ? id_plus1 : next_id_ff;

   always_comb begin
      next_id_in = next_id_ff;
      if (take && push) begin
         next_id_in = give_id + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff <= 32'd1;
      end else begin
         next_id_ff <= next_id_in;
      end
   end

   always_comb begin
      cmd.do_push      = push;
      cmd.do_mark      = (req.func == pgt_pkg::FUNC_COMPLETE) ||
                         (req.func == pgt_pkg::FUNC_CANCEL);
      cmd.status       = (req.func == pgt_pkg::FUNC_CANCEL) ? pgt_pkg::ST_CANCELLED :
                         (req.success ? pgt_pkg::ST_COMPLETED : pgt_pkg::ST_FAILED);
      cmd.goal_id      = req.goal_id;
      cmd.priority_req = req.priority_req;
      cmd.current_step = req.current_step;
      cmd.new_id       = push ? give_id : 32'd0;
   end

endmodule
`default_nettype wire

### hw/rtl/pgt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Goal table command queue
// Short queue between the front end and the engine.
// ----------------------------------------------------------------------------
module pgt_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  pgt_pkg::cmd_type  push_data,
   input  wire               pop,
   output pgt_pkg::cmd_type  head,
   output logic              not_empty,
   output logic              full
);

   localparam int unsigned DEPTH = pgt_pkg::QUEUE_DEPTH;
   localparam int unsigned AW    = $clog2(DEPTH);

   pgt_pkg::cmd_type  store_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;

   assign head      = store_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == (AW+1)'(DEPTH));

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/pgt_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Goal table engine
// Scans the slot memory to mark, evict, insert and report the best open goal.
// ----------------------------------------------------------------------------
module pgt_engine #(
   parameter int unsigned GOAL_SLOTS = pgt_pkg::GOAL_SLOTS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               cmd_valid,
   input  pgt_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   input  wire  [7:0]        goal_limit,
   output logic              rsp_valid,
   output pgt_pkg::rsp_type  rsp
);

   localparam int unsigned IW = (GOAL_SLOTS > 1) ? $clog2(GOAL_SLOTS) : 1;
   localparam int unsigned CW = $clog2(GOAL_SLOTS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN1 = 3'd1;   // match, victim, count, free slot
   localparam logic [2:0] S_APPLY = 3'd2;
   localparam logic [2:0] S_SCAN2 = 3'd3;   // best open goal and open count
   localparam logic [2:0] S_DONE  = 3'd4;

   typedef struct packed {
      logic [31:0] id;
      logic [15:0] prio;
      logic [1:0]  status;
      logic [47:0] updated;
   } slot_type;

   slot_type          mem [GOAL_SLOTS];
   logic [GOAL_SLOTS-1:0] used_ff, used_in;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;       // address being read
   logic              rv_ff, rv_in;         // read data valid for rd_idx_ff
   logic [IW-1:0]     rd_idx_ff;
   slot_type          rd_ff;
   pgt_pkg::cmd_type  c_ff, c_in;

   logic              match_v_ff, match_v_in;
   logic [IW-1:0]     match_ff, match_in;
   logic              vic_v_ff, vic_v_in;
   logic [IW-1:0]     vic_ff, vic_in;
   slot_type          vic_d_ff, vic_d_in;
   logic              free_v_ff, free_v_in;
   logic [IW-1:0]     free_ff, free_in;
   logic [CW-1:0]     used_cnt_ff, used_cnt_in;
   logic              best_v_ff, best_v_in;
   logic [31:0]       best_id_ff, best_id_in;
   logic [15:0]       best_pr_ff, best_pr_in;
   logic [CW-1:0]     open_ff, open_in;
   logic              found_ff, found_in;

   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   slot_type          wr_data;
   logic [CW-1:0]     limit;
   logic              last;
   logic              rd_used;
   logic              vic_better;
   logic              evict;
   logic              ins_v;
   logic [IW-1:0]     ins_slot;

   always_comb begin
      if (goal_limit == 8'd0) begin
         limit = CW'(1);
      end else if ({{(32-8){1'b0}}, goal_limit} > 32'(GOAL_SLOTS)) begin
         limit = CW'(GOAL_SLOTS);
      end else begin
         limit = CW'(goal_limit);
      end
   end

   assign last    = (idx_ff == CW'(GOAL_SLOTS));
   assign rd_used = rv_ff && used_ff[rd_idx_ff];

   // Eviction order: finished first, lower priority, older step, lower id.
   always_comb begin
      if ((rd_ff.status != pgt_pkg::ST_PENDING) != (vic_d_ff.status != pgt_pkg::ST_PENDING)) begin
         vic_better = (rd_ff.status != pgt_pkg::ST_PENDING);
      end else if (rd_ff.prio != vic_d_ff.prio) begin
         vic_better = rd_ff.prio < vic_d_ff.prio;
      end else if (rd_ff.updated != vic_d_ff.updated) begin
         vic_better = rd_ff.updated < vic_d_ff.updated;
      end else begin
         vic_better = rd_ff.id < vic_d_ff.id;
      end
   end

   assign evict = c_ff.do_push && vic_v_ff && (used_cnt_ff >= limit);

   // Lowest free slot after the eviction.
   always_comb begin
      ins_v    = free_v_ff;
      ins_slot = free_ff;
      if (evict && (!free_v_ff || vic_ff < free_ff)) begin
         ins_v    = 1'b1;
         ins_slot = vic_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      rv_in       = 1'b0;
      c_in        = c_ff;
      used_in     = used_ff;
      match_v_in  = match_v_ff;
      match_in    = match_ff;
      vic_v_in    = vic_v_ff;
      vic_in      = vic_ff;
      vic_d_in    = vic_d_ff;
      free_v_in   = free_v_ff;
      free_in     = free_ff;
      used_cnt_in = used_cnt_ff;
      best_v_in   = best_v_ff;
      best_id_in  = best_id_ff;
      best_pr_in  = best_pr_ff;
      open_in     = open_ff;
      found_in    = found_ff;
      cmd_pop     = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = match_ff;
      wr_data     = rd_ff;
      rsp_valid   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               c_in        = cmd;
               idx_in      = '0;
               match_v_in  = 1'b0;
               vic_v_in    = 1'b0;
               free_v_in   = 1'b0;
               used_cnt_in = '0;
               found_in    = 1'b0;
               state_in    = S_SCAN1;
            end
         end
         S_SCAN1: begin
            if (!last) begin
               idx_in = idx_ff + CW'(1);
               rv_in  = 1'b1;
            end
            if (rv_ff) begin
               if (rd_used) begin
                  used_cnt_in = used_cnt_ff + CW'(1);
                  if (!match_v_ff && rd_ff.id == c_ff.goal_id) begin
                     match_v_in = 1'b1;
                     match_in   = rd_idx_ff;
                  end
                  if (!vic_v_ff || vic_better) begin
                     vic_v_in = 1'b1;
                     vic_in   = rd_idx_ff;
                     vic_d_in = rd_ff;
                  end
               end else if (!free_v_ff) begin
                  free_v_in = 1'b1;
                  free_in   = rd_idx_ff;
               end
            end
            if (last && !rv_ff) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (c_ff.do_push) begin
               if (evict) begin
                  used_in[vic_ff] = 1'b0;
               end
               if (ins_v) begin
                  used_in[ins_slot] = 1'b1;
                  wr_en        = 1'b1;
                  wr_addr      = ins_slot;
                  wr_data.id      = c_ff.new_id;
                  wr_data.prio    = c_ff.priority_req;
                  wr_data.status  = pgt_pkg::ST_PENDING;
                  wr_data.updated = c_ff.current_step;
               end
            end else if (c_ff.do_mark && match_v_ff) begin
               found_in = 1'b1;
               wr_en    = 1'b1;
               wr_addr  = match_ff;
               wr_data  = slot_type'({32'd0, 16'd0, c_ff.status, c_ff.current_step});
            end
            idx_in    = '0;
            best_v_in = 1'b0;
            open_in   = '0;
            state_in  = S_SCAN2;
         end
         S_SCAN2: begin
            if (!last) begin
               idx_in = idx_ff + CW'(1);
               rv_in  = 1'b1;
            end
            if (rd_used && rd_ff.status == pgt_pkg::ST_PENDING) begin
               open_in = open_ff + CW'(1);
               if (!best_v_ff || rd_ff.prio > best_pr_ff ||
                   (rd_ff.prio == best_pr_ff && rd_ff.id > best_id_ff)) begin
                  best_v_in  = 1'b1;
                  best_id_in = rd_ff.id;
                  best_pr_in = rd_ff.prio;
               end
            end
            if (last && !rv_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp.new_id          = c_ff.new_id;
      rsp.found           = found_ff;
      rsp.active_valid    = best_v_ff;
      rsp.active_id       = best_v_ff ? best_id_ff : 32'd0;
      rsp.active_priority = best_v_ff ? best_pr_ff : 16'd0;
      rsp.open_count      = (32'(open_ff) > 32'd255) ? 8'd255 : 8'(open_ff);
   end

   // A mark only rewrites status and step; id and priority are kept.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (c_ff.do_push) begin
            mem[wr_addr] <= wr_data;
         end else begin
            mem[wr_addr].status  <= wr_data.status;
            mem[wr_addr].updated <= wr_data.updated;
         end
      end
      rd_ff     <= mem[idx_ff[IW-1:0]];
      rd_idx_ff <= idx_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      c_ff        <= c_in;
      match_v_ff  <= match_v_in;
      match_ff    <= match_in;
      vic_v_ff    <= vic_v_in;
      vic_ff      <= vic_in;
      vic_d_ff    <= vic_d_in;
      free_v_ff   <= free_v_in;
      free_ff     <= free_in;
      used_cnt_ff <= used_cnt_in;
      best_v_ff   <= best_v_in;
      best_id_ff  <= best_id_in;
      best_pr_ff  <= best_pr_in;
      open_ff     <= open_in;
      found_ff    <= found_in;
   end

endmodule
`default_nettype wire

### bench/goal_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Goal table checker
// Watches the request, response and register ports of the goal table, keeps
// its own copy of the table and compares each response with its prediction.
// ----------------------------------------------------------------------------
module goal_table_checker
   import pgt_pkg::*;
#(
   parameter int unsigned SLOTS = 128
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   input  wire          busy,
   input  req_type      req_data,
   input  wire          rsp_strobe,
   input  rsp_type      rsp_data,
   input  wire          csr_we,
   input  wire  [7:0]   csr_index,
   input  wire  [7:0]   csr_wdata,
   output int           failures,
   output int           outstanding
);

   logic        used_q    [SLOTS];
   logic [31:0] id_q      [SLOTS];
   logic [15:0] prio_q    [SLOTS];
   logic [1:0]  status_q  [SLOTS];
   logic [47:0] updated_q [SLOTS];
   logic [31:0] next_id_q;
   logic        enable_q;
   logic [7:0]  limit_q;

   rsp_type expected_rsps[$];

   assign outstanding = expected_rsps.size();

   function automatic bit evicts_first(int a, int b);
      bit fa, fb;
      fa = status_q[a] != ST_PENDING;
      fb = status_q[b] != ST_PENDING;
      if (fa != fb) return fa;
      if (prio_q[a] != prio_q[b]) return prio_q[a] < prio_q[b];
      if (updated_q[a] != updated_q[b]) return updated_q[a] < updated_q[b];
      return id_q[a] < id_q[b];
   endfunction

   function automatic logic [31:0] add_goal(logic [15:0] prio, logic [47:0] step);
      int unsigned lim, fill;
      int victim, free_slot;
      logic [31:0] gid;
      lim = (limit_q == 0) ? 1 : limit_q;
      if (lim > SLOTS) lim = SLOTS;
      fill = 0;
      victim = -1;
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (used_q[i]) begin
            fill++;
            if (victim < 0 || evicts_first(i, victim)) victim = i;
         end
      end
      if (fill >= lim && victim >= 0) used_q[victim] = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!used_q[i] && free_slot < 0) free_slot = i;
      end
      gid = next_id_q;
      next_id_q = next_id_q + 1;
      if (gid == 0) begin
         gid = next_id_q;
         next_id_q = next_id_q + 1;
      end
      if (free_slot >= 0) begin
         used_q[free_slot] = 1'b1;
         id_q[free_slot] = gid;
         prio_q[free_slot] = prio;
         status_q[free_slot] = ST_PENDING;
         updated_q[free_slot] = step;
      end
      return gid;
   endfunction

   function automatic bit mark_goal(logic [31:0] gid, logic [1:0] st, logic [47:0] step);
      for (int i = 0; i < SLOTS; i++) begin
         if (used_q[i] && id_q[i] == gid) begin
            status_q[i] = st;
            updated_q[i] = step;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_type table_response(req_type r);
      rsp_type o;
      int best;
      int unsigned open_goals;
      o = '0;
      best = -1;
      open_goals = 0;
      case (r.func)
         FUNC_PUSH: begin
            if (enable_q) o.new_id = add_goal(r.priority_req, r.current_step);
         end
         FUNC_COMPLETE: begin
            o.found = mark_goal(r.goal_id, r.success ? ST_COMPLETED : ST_FAILED,
                                r.current_step);
         end
         FUNC_CANCEL: begin
            o.found = mark_goal(r.goal_id, ST_CANCELLED, r.current_step);
         end
         default: ;
      endcase
      for (int i = 0; i < SLOTS; i++) begin
         if (used_q[i] && status_q[i] == ST_PENDING) begin
            open_goals++;
            if (best < 0 || prio_q[i] > prio_q[best] ||
                (prio_q[i] == prio_q[best] && id_q[i] > id_q[best])) best = i;
         end
      end
      if (open_goals > 255) open_goals = 255;
      if (best >= 0) begin
         o.active_valid = 1'b1;
         o.active_id = id_q[best];
         o.active_priority = prio_q[best];
      end
      o.open_count = open_goals[7:0];
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) used_q[i] = 1'b0;
         next_id_q = 32'd1;
         enable_q = 1'b1;
         limit_q = 8'd128;
         expected_rsps.delete();
         failures <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               failures <= failures + 1;
            end else begin
               rsp_type e;
               int errs;
               e = expected_rsps.pop_front();
               errs = 0;
               if (rsp_data.new_id !== e.new_id) begin
                  $error("new_id: expected %0d, got %0d", e.new_id, rsp_data.new_id);
                  errs++;
               end
               if (rsp_data.found !== e.found) begin
                  $error("found: expected %0d, got %0d", e.found, rsp_data.found);
                  errs++;
               end
               if (rsp_data.active_valid !== e.active_valid) begin
                  $error("active_valid: expected %0d, got %0d",
                         e.active_valid, rsp_data.active_valid);
                  errs++;
               end
               if (rsp_data.active_id !== e.active_id) begin
                  $error("active_id: expected %0d, got %0d", e.active_id, rsp_data.active_id);
                  errs++;
               end
               if (rsp_data.active_priority !== e.active_priority) begin
                  $error("active_priority: expected %0d, got %0d",
                         e.active_priority, rsp_data.active_priority);
                  errs++;
               end
               if (rsp_data.open_count !== e.open_count) begin
                  $error("open_count: expected %0d, got %0d",
                         e.open_count, rsp_data.open_count);
                  errs++;
               end
               failures <= failures + errs;
            end
         end
         if (start && !busy) expected_rsps = {expected_rsps, table_response(req_data)};
         if (csr_we) begin
            if (csr_index == CSR_ENABLE) enable_q = csr_wdata[0];
            else if (csr_index == CSR_LIMIT) limit_q = csr_wdata;
         end
      end
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Goal table testbench
// Drives directed and random requests through several register settings and
// lets the checker compare every response with its own model of the table.
// ----------------------------------------------------------------------------
module tb_top;
   import pgt_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic       csr_we = 1'b0;
   logic [7:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;
   int failures;
   int outstanding;
   int unsigned ids_issued = 0;
   logic [47:0] step_count = '0;

   always #2 clock = ~clock;

   priority_goal_table_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   goal_table_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .outstanding(outstanding)
   );

   initial begin
      #15ms;
      $display("FAIL priority_goal_table_top");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   // with start still high.
   task automatic issue(logic [1:0] f, logic [31:0] gid, logic [15:0] prio,
                        logic ok, logic [47:0] step);
      req_data = '{func: f, goal_id: gid, priority_req: prio, success: ok,
                   current_step: step};
      start = 1'b1;
      if (f == FUNC_PUSH) ids_issued++;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int unsigned r, n;
      r = $urandom_range(99);
      n = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 6) : $urandom_range(20, 300);
      if (n > 0) begin
         start = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain();
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [7:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic random_request();
      int unsigned r;
      logic [1:0] f;
      logic [31:0] gid;
      logic [15:0] prio;
      logic [47:0] step;
      r = $urandom_range(99);
      f = (r < 40) ? FUNC_PUSH : (r < 62) ? FUNC_COMPLETE : (r < 80) ? FUNC_CANCEL
                                                                    : FUNC_QUERY;
      // Mostly ids that were handed out recently, so that marks hit.
      if ($urandom_range(9) == 0) gid = $urandom;
      else gid = $urandom_range(ids_issued + 2, (ids_issued > 150) ? ids_issued - 150 : 0);
      // A narrow priority set provokes ties in both the search and eviction.
      prio = ($urandom_range(1) == 0) ? 16'($urandom_range(3)) * 16'h5555 : 16'($urandom);
      step_count = step_count + 48'($urandom_range(2));
      step = ($urandom_range(7) == 0) ? {16'($urandom), 32'($urandom)} : step_count;
      issue(f, gid, prio, 1'($urandom), step);
      idle_gap();
   endtask

   initial begin
      logic [7:0] limits[7] = '{8'd128, 8'd1, 8'd4, 8'd8, 8'd255, 8'd0, 8'd17};
      logic       enables[7] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed part: extremes of the fields and every command.
      issue(FUNC_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 48'hFFFF_FFFF_FFFF);
      issue(FUNC_PUSH, 32'd0, 16'd0, 1'b0, 48'd0);
      issue(FUNC_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 48'hFFFF_FFFF_FFFF);
      issue(FUNC_PUSH, 32'd0, 16'hFFFF, 1'b0, 48'd5);
      issue(FUNC_PUSH, 32'd0, 16'h8000, 1'b0, 48'd6);
      issue(FUNC_COMPLETE, 32'd3, 16'd0, 1'b1, 48'd7);
      issue(FUNC_COMPLETE, 32'd2, 16'd0, 1'b0, 48'd8);
      issue(FUNC_CANCEL, 32'd4, 16'd0, 1'b0, 48'd9);
      issue(FUNC_CANCEL, 32'd4, 16'd0, 1'b0, 48'd10);
      issue(FUNC_COMPLETE, 32'd4, 16'd0, 1'b1, 48'd11);
      issue(FUNC_CANCEL, 32'hFFFF_FFFF, 16'd0, 1'b1, 48'd12);
      issue(FUNC_COMPLETE, 32'd0, 16'd0, 1'b0, 48'd13);
      issue(FUNC_QUERY, 32'd1, 16'd0, 1'b0, 48'd14);
      drain();
      // Small limit: each push evicts, finished entries first.
      write_reg(8'(CSR_LIMIT), 8'd2);
      issue(FUNC_PUSH, 32'd0, 16'd1, 1'b0, 48'd20);
      issue(FUNC_PUSH, 32'd0, 16'd1, 1'b0, 48'd20);
      issue(FUNC_PUSH, 32'd0, 16'd1, 1'b0, 48'd19);
      issue(FUNC_QUERY, 32'd0, 16'd0, 1'b0, 48'd21);
      drain();
      write_reg(8'(CSR_ENABLE), 8'd0);
      issue(FUNC_PUSH, 32'd0, 16'hFFFF, 1'b0, 48'd22);
      issue(FUNC_CANCEL, 32'd1, 16'd0, 1'b0, 48'd23);
      issue(FUNC_QUERY, 32'd0, 16'd0, 1'b0, 48'd24);
      drain();
      write_reg(8'(CSR_ENABLE), 8'd1);
      write_reg(8'(CSR_LIMIT), 8'd128);

      for (int p = 0; p < 7; p++) begin
         drain();
         write_reg(8'(CSR_ENABLE), 8'(enables[p]));
         write_reg(8'(CSR_LIMIT), limits[p]);
         for (int k = 0; k < 250; k++) begin
            random_request();
            // Now and then the sender waits for the table to answer everything.
            if ($urandom_range(99) == 0) drain();
         end
      end

      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (failures == 0) begin
         $display("PASS priority_goal_table_top");
      end else begin
         $display("FAIL priority_goal_table_top");
      end
      $finish;
   end

endmodule

### priority_goal_table_top.f
hw/rtl/pgt_pkg.sv
hw/rtl/pgt_front.sv
hw/rtl/pgt_queue.sv
hw/rtl/pgt_engine.sv
hw/rtl/priority_goal_table_top.sv
bench/goal_table_checker.sv
bench/tb_top.sv
